// ===== rtl/core/mqps_pkg.sv =====
// Package: shared types, operation and status codes, register map and reset values.
`default_nettype none
package mqps_pkg;

  // Default sizing handed to the top level
  localparam int DEF_SOURCES     = 4;
  localparam int DEF_QUEUE_DEPTH = 64;
  localparam int DEF_TIME_BITS   = 40;

  // Operation codes
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_FILL  = 3'd1;
  localparam logic [2:0] OP_END   = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_SEEK  = 3'd4;
  localparam logic [2:0] OP_START = 3'd5;
  localparam logic [2:0] OP_STOP  = 3'd6;
  localparam logic [2:0] OP_NONE  = 3'd7;

  // Status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_EMPTY_ENDED = 3'd1;
  localparam logic [2:0] ST_EMPTY       = 3'd2;
  localparam logic [2:0] ST_FULL        = 3'd3;
  localparam logic [2:0] ST_NOT_STARTED = 3'd4;

  // Register map
  localparam logic [1:0] REG_MAX_DURATION = 2'd0;
  localparam logic [1:0] REG_MAX_BYTES    = 2'd1;
  localparam logic [1:0] REG_LOW_WATER    = 2'd2;
  localparam logic [1:0] REG_SOURCE_COUNT = 2'd3;

  localparam logic [39:0] RST_MAX_DURATION = 40'd60000000;
  localparam logic [31:0] RST_MAX_BYTES    = 32'd5242880;
  localparam logic [39:0] RST_LOW_WATER    = 40'd5000000;
  localparam logic [2:0]  RST_SOURCE_COUNT = 3'd1;

  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  source;
    logic [39:0] time_us;
    logic [20:0] size_bytes;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        fill_request;
    logic [1:0]  fill_source;
    logic        filling;
    logic [39:0] min_duration_us;
    logic        no_more_data;
    logic [39:0] read_time_us;
    logic [20:0] read_size_bytes;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/multi_queue_prefetch_scheduler_core.sv =====
// Top level: per-source timestamp queues in one entry memory with a fill scheduler.
`default_nettype none
// Usage
//   Command port: an item (item) is taken at a clock edge with start high and busy
//   low. Exactly one result follows on result, marked by done for a single cycle;
//   the receiver must take it then, it cannot stall the block.
//   Configuration: cfg_we writes cfg_data to register cfg_addr at once; write
//   only while busy is low and no result is pending.
// Sequence
//   An item is executed when it is taken, then the scan loop visits each source
//   in use (source_count, at least one, at most SOURCES) in turn, then the
//   result is formed; a read that pops an entry first passes S_POP and S_HEAD
//   for the two entry-memory accesses (popped entry, new head).
//   The next item may be given in the cycle in which done is high.
// Reset
//   rst (synchronous) empties all queues, clears started, ended and filling
//   flags and loads the register reset values. The entry memory is not
//   cleared; a value read from a slot that holds no entry is never used.
module multi_queue_prefetch_scheduler_core #(
  parameter int SOURCES     = mqps_pkg::DEF_SOURCES,
  parameter int QUEUE_DEPTH = mqps_pkg::DEF_QUEUE_DEPTH,
  parameter int TIME_BITS   = mqps_pkg::DEF_TIME_BITS
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  output logic                   busy,
  input  wire mqps_pkg::item_t   item,
  output logic                   done,
  output mqps_pkg::result_t      result,
  input  wire                    cfg_we,
  input  wire  [1:0]             cfg_addr,
  input  wire  [39:0]            cfg_data
);
  import mqps_pkg::*;

  localparam int SW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = (SOURCES * QUEUE_DEPTH > 2) ? $clog2(SOURCES * QUEUE_DEPTH) : 1;
  localparam int MD = SOURCES * QUEUE_DEPTH;
  localparam int DW = (TIME_BITS > 40) ? TIME_BITS + 2 : 42;
  localparam int EW = TIME_BITS + 21;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POP  = 3'd1;
  localparam logic [2:0] S_HEAD = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  // Configuration registers
  logic [39:0] max_duration;
  logic [31:0] max_bytes;
  logic [39:0] low_water;
  logic [2:0]  source_count;

  // Per-source queue state
  logic [PW-1:0]        head_ptr  [SOURCES];
  logic [PW-1:0]        tail_ptr  [SOURCES];
  logic [CW-1:0]        entry_cnt [SOURCES];
  logic [31:0]          byte_total[SOURCES];
  logic                 started   [SOURCES];
  logic                 ended     [SOURCES];
  logic [TIME_BITS-1:0] head_time [SOURCES];
  logic [TIME_BITS-1:0] last_time [SOURCES];
  logic                 fill_flag;

  // Entry memory
  logic [EW-1:0] mem [MD];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;

  // Sequencer
  logic [2:0]    state;
  logic [2:0]    cur_op;
  logic [SW-1:0] cur_src;
  logic [2:0]    status;
  logic [39:0]   rd_time;
  logic [20:0]   rd_size;
  logic [SW-1:0] wi;
  logic          found;
  logic signed [DW-1:0] best;
  logic [SW-1:0] best_idx;
  logic signed [DW-1:0] mind;
  logic          any_active;

  logic [SW-1:0]        si;
  logic                 src_ok;
  logic [TIME_BITS-1:0] t_in;
  logic [4:0]           n_use;
  logic                 walk_last;
  logic signed [DW-1:0] d_w;
  logic                 elig;
  logic [32:0]          byte_sum;
  logic [PW-1:0]        head_inc;
  logic                 fill_next;
  logic signed [DW-1:0] max_dur_s;
  logic signed [DW-1:0] low_s;

  function automatic logic [AW-1:0] slot(input logic [SW-1:0] s, input logic [PW-1:0] p);
    slot = AW'(s) * AW'(QUEUE_DEPTH) + AW'(p);
  endfunction

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    wrap_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign si        = SW'(item.source);
  assign src_ok    = int'(item.source) < SOURCES;
  assign t_in      = TIME_BITS'(item.time_us);
  assign busy      = (state != S_IDLE);
  assign n_use     = (source_count == 3'd0) ? 5'd1 :
                     (5'(source_count) > 5'(SOURCES)) ? 5'(SOURCES) : 5'(source_count);
  assign walk_last = (5'(wi) + 5'd1) >= n_use;
  assign byte_sum  = {1'b0, byte_total[si]} + 33'(item.size_bytes);
  assign head_inc  = wrap_inc(head_ptr[cur_src]);
  assign max_dur_s = $signed(DW'(max_duration));
  assign low_s     = $signed(DW'(low_water));

  // Duration and eligibility of the source under scan
  always_comb begin
    if (entry_cnt[wi] < CW'(2)) begin
      d_w = '0;
    end else begin
      d_w = $signed(DW'(last_time[wi])) - $signed(DW'(head_time[wi]));
    end
    elig = started[wi] && !ended[wi] && !(byte_total[wi] > max_bytes) &&
           !((n_use > 5'd1) && (d_w >= max_dur_s));
  end

  // Tick decision from the scan results
  always_comb begin
    if (!found) begin
      fill_next = 1'b0;
    end else begin
      fill_next = fill_flag || (best < low_s);
    end
  end

  // Memory port control
  always_comb begin
    mem_we    = (state == S_IDLE) && start && (item.op == OP_FILL) && src_ok &&
                started[si] && (entry_cnt[si] != CW'(QUEUE_DEPTH));
    mem_waddr = slot(si, tail_ptr[si]);
    mem_wdata = {t_in, item.size_bytes};
    if (state == S_POP) begin
      mem_re    = 1'b1;
      mem_raddr = slot(cur_src, head_inc);
    end else begin
      mem_re    = (state == S_IDLE) && start && (item.op == OP_READ);
      mem_raddr = slot(si, head_ptr[si]);
    end
  end

  // Entry memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_duration <= RST_MAX_DURATION;
      max_bytes    <= RST_MAX_BYTES;
      low_water    <= RST_LOW_WATER;
      source_count <= RST_SOURCE_COUNT;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MAX_DURATION: max_duration <= cfg_data;
        REG_MAX_BYTES:    max_bytes    <= cfg_data[31:0];
        REG_LOW_WATER:    low_water    <= cfg_data;
        REG_SOURCE_COUNT: source_count <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Sequencer: execute, pop, reload head, scan, result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      fill_flag <= 1'b0;
      for (int i = 0; i < SOURCES; i++) begin
        head_ptr[i]   <= '0;
        tail_ptr[i]   <= '0;
        entry_cnt[i]  <= '0;
        byte_total[i] <= '0;
        started[i]    <= 1'b0;
        ended[i]      <= 1'b0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cur_op     <= item.op;
            cur_src    <= si;
            status     <= ST_OK;
            rd_time    <= '0;
            rd_size    <= '0;
            wi         <= '0;
            found      <= 1'b0;
            best       <= '0;
            best_idx   <= '0;
            mind       <= '0;
            any_active <= 1'b0;
            state      <= S_WALK;
            if (item.op == OP_TICK || item.op == OP_NONE) begin
              // nothing to execute
            end else if (!src_ok) begin
              status <= ST_NOT_STARTED;
            end else if (item.op == OP_START) begin
              started[si] <= 1'b1;
            end else if (!started[si]) begin
              status <= ST_NOT_STARTED;
            end else begin
              case (item.op)
                OP_FILL: begin
                  if (entry_cnt[si] == CW'(QUEUE_DEPTH)) begin
                    status <= ST_FULL;
                  end else begin
                    tail_ptr[si]   <= wrap_inc(tail_ptr[si]);
                    entry_cnt[si]  <= entry_cnt[si] + CW'(1);
                    byte_total[si] <= byte_sum[32] ? '1 : byte_sum[31:0];
                    last_time[si]  <= t_in;
                    if (entry_cnt[si] == '0) begin
                      head_time[si] <= t_in;
                    end
                  end
                end
                OP_END: ended[si] <= 1'b1;
                OP_READ: begin
                  if (entry_cnt[si] == '0) begin
                    status <= ended[si] ? ST_EMPTY_ENDED : ST_EMPTY;
                  end else begin
                    state <= S_POP;
                  end
                end
                OP_SEEK, OP_STOP: begin
                  head_ptr[si]   <= '0;
                  tail_ptr[si]   <= '0;
                  entry_cnt[si]  <= '0;
                  byte_total[si] <= '0;
                  if (item.op == OP_SEEK) begin
                    ended[si] <= 1'b0;
                  end else begin
                    started[si] <= 1'b0;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        S_POP: begin
          // popped entry is back: advance head, drop its bytes
          rd_time             <= 40'(mem_rdata[EW-1:21]);
          rd_size             <= mem_rdata[20:0];
          head_ptr[cur_src]   <= head_inc;
          entry_cnt[cur_src]  <= entry_cnt[cur_src] - CW'(1);
          byte_total[cur_src] <= (byte_total[cur_src] > 32'(mem_rdata[20:0])) ?
                                 byte_total[cur_src] - 32'(mem_rdata[20:0]) : '0;
          state               <= S_HEAD;
        end
        S_HEAD: begin
          head_time[cur_src] <= mem_rdata[EW-1:21];
          state              <= S_WALK;
        end
        S_WALK: begin
          if (started[wi] && !ended[wi]) begin
            any_active <= 1'b1;
          end
          if (wi == '0 || d_w < mind) begin
            mind <= d_w;
          end
          if (elig && (!found || d_w < best)) begin
            found    <= 1'b1;
            best     <= d_w;
            best_idx <= wi;
          end
          wi <= wi + SW'(1);
          if (walk_last) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (cur_op == OP_TICK) begin
            fill_flag           <= fill_next;
            result.fill_request <= fill_next;
            result.fill_source  <= fill_next ? 2'(best_idx) : 2'd0;
            result.filling      <= fill_next;
          end else begin
            result.fill_request <= 1'b0;
            result.fill_source  <= 2'd0;
            result.filling      <= fill_flag;
          end
          result.status          <= status;
          result.min_duration_us <= mind[DW-1] ? 40'd0 : mind[39:0];
          result.no_more_data    <= !any_active;
          result.read_time_us    <= rd_time;
          result.read_size_bytes <= rd_size;
          done                   <= 1'b1;
          state                  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not start the sequencer");
  a_req_filling: assert property (@(posedge clk) disable iff (rst)
    (done && result.fill_request) |-> result.filling)
    else $error("fill request without filling flag");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_cnt[0] <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_FIN)
    else $error("result strobe outside the result step");

endmodule
`default_nettype wire

// ===== dv/multi_queue_prefetch_scheduler_core_test.sv =====
// Self-checking bench for the multi-queue prefetch scheduler core: directed table, a fill past full, then random.
`timescale 1ns / 100ps
`default_nettype none
module multi_queue_prefetch_scheduler_core_test;
  import mqps_pkg::*;

  localparam int NSRC  = 4;
  localparam int DEPTH = 64;
  localparam logic [39:0] T_MAX = 40'hFF_FFFF_FFFF;
  localparam logic [20:0] SZ_MAX = 21'd1048576;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  item_t item = '0;
  logic done;
  result_t result;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [39:0] cfg_data = '0;

  multi_queue_prefetch_scheduler_core i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Shadow state of the scheduler
  logic [39:0] q_time [NSRC][DEPTH];
  logic [20:0] q_size [NSRC][DEPTH];
  int unsigned q_head [NSRC];
  int unsigned q_tail [NSRC];
  int unsigned q_cnt [NSRC];
  logic [31:0] q_bytes [NSRC];
  bit src_started [NSRC];
  bit src_ended [NSRC];
  bit fill_on;
  logic [39:0] lim_dur;
  logic [31:0] lim_bytes;
  logic [39:0] low_water;
  logic [2:0] src_cnt;

  result_t pending_results [$];
  int mismatches = 0;
  bit quiet = 1'b0;

  function automatic longint buffered_dur(int s);
    int unsigned last;
    if (q_cnt[s] < 2) return 0;
    last = (q_tail[s] == 0) ? DEPTH - 1 : q_tail[s] - 1;
    return longint'({24'd0, q_time[s][last]}) - longint'({24'd0, q_time[s][q_head[s]]});
  endfunction

  function automatic void drop_queue(int s);
    q_head[s] = 0; q_tail[s] = 0; q_cnt[s] = 0; q_bytes[s] = 0;
  endfunction

  // Advance the shadow state by one item and form its result
  function automatic result_t schedule_step(item_t it);
    result_t r;
    int n, s, bi;
    longint d, best, mind;
    bit found, active;
    logic [32:0] sum;
    r = '0;
    n = (src_cnt == 0) ? 1 : (src_cnt > NSRC) ? NSRC : src_cnt;
    s = it.source;
    if (it.op == OP_TICK) begin
      found = 0; best = 0; bi = 0;
      for (int i = 0; i < n; i++) begin
        d = buffered_dur(i);
        if (!src_started[i] || src_ended[i]) continue;
        if (q_bytes[i] > lim_bytes) continue;
        if (n > 1 && d >= longint'({24'd0, lim_dur})) continue;
        if (!found || d < best) begin
          found = 1; best = d; bi = i;
        end
      end
      if (!found) fill_on = 0;
      else begin
        if (!fill_on && best < longint'({24'd0, low_water})) fill_on = 1;
        r.fill_request = fill_on;
        r.fill_source = fill_on ? bi[1:0] : 2'd0;
      end
    end else if (it.op == OP_NONE) begin
    end else if (it.op == OP_START) begin
      src_started[s] = 1;
    end else if (!src_started[s]) begin
      r.status = ST_NOT_STARTED;
    end else if (it.op == OP_FILL) begin
      if (q_cnt[s] >= DEPTH) r.status = ST_FULL;
      else begin
        q_time[s][q_tail[s]] = it.time_us;
        q_size[s][q_tail[s]] = it.size_bytes;
        q_tail[s] = (q_tail[s] + 1 >= DEPTH) ? 0 : q_tail[s] + 1;
        q_cnt[s]++;
        sum = {1'b0, q_bytes[s]} + it.size_bytes;
        q_bytes[s] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end
    end else if (it.op == OP_END) begin
      src_ended[s] = 1;
    end else if (it.op == OP_READ) begin
      if (q_cnt[s] == 0) r.status = src_ended[s] ? ST_EMPTY_ENDED : ST_EMPTY;
      else begin
        r.read_time_us = q_time[s][q_head[s]];
        r.read_size_bytes = q_size[s][q_head[s]];
        q_head[s] = (q_head[s] + 1 >= DEPTH) ? 0 : q_head[s] + 1;
        q_cnt[s]--;
        q_bytes[s] = (q_bytes[s] > r.read_size_bytes) ? q_bytes[s] - r.read_size_bytes : 0;
      end
    end else if (it.op == OP_SEEK) begin
      drop_queue(s); src_ended[s] = 0;
    end else begin
      drop_queue(s); src_started[s] = 0;
    end
    active = 0; mind = 0;
    for (int i = 0; i < n; i++) begin
      d = buffered_dur(i);
      if (src_started[i] && !src_ended[i]) active = 1;
      if (i == 0 || d < mind) mind = d;
    end
    if (mind < 0) mind = 0;
    r.filling = fill_on;
    r.min_duration_us = mind[39:0];
    r.no_more_data = !active;
    return r;
  endfunction

  // Compare each transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result);
      end else begin
        result_t e;
        e = pending_results.pop_front();
        if (result !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d fr=%0d fs=%0d f=%0d md=%h nm=%0d rt=%h rs=%h",
                     e.status, e.fill_request, e.fill_source, e.filling,
                     e.min_duration_us, e.no_more_data, e.read_time_us,
                     e.read_size_bytes, "\n          got st=%0d fr=%0d fs=%0d f=%0d md=%h nm=%0d rt=%h rs=%h",
                     result.status, result.fill_request, result.fill_source,
                     result.filling, result.min_duration_us, result.no_more_data,
                     result.read_time_us, result.read_size_bytes);
        end
      end
    end
  end

  // Now and then, unless quiet, drop start for a random burst of cycles
  task automatic idle_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Hand one item over and queue its expectation; check a typed-in value if given
  task automatic issue(item_t it, bit has_exp = 0, result_t exp_r = '0);
    result_t p;
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    p = schedule_step(it);
    if (has_exp && p !== exp_r) begin
      mismatches++;
      if (mismatches <= 10) $display("table row disagrees with predictor: %h vs %h", exp_r, p);
    end
    pending_results.insert(pending_results.size(), p);
    idle_gap();
  endtask

  task automatic write_reg(logic [1:0] idx, logic [39:0] val);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAX_DURATION: lim_dur = val;
      REG_MAX_BYTES:    lim_bytes = val[31:0];
      REG_LOW_WATER:    low_water = val;
      default:          src_cnt = val[2:0];
    endcase
  endtask

  function automatic item_t mk(logic [2:0] op, logic [1:0] s, logic [39:0] t, logic [20:0] z);
    item_t it;
    it.op = op; it.source = s; it.time_us = t; it.size_bytes = z;
    return it;
  endfunction

  typedef struct {
    item_t it;
    bit has_exp;
    result_t exp_r;
  } row_t;

  function automatic row_t mk_row(item_t it, bit has_exp, result_t exp_r);
    row_t rw;
    rw.it = it; rw.has_exp = has_exp; rw.exp_r = exp_r;
    return rw;
  endfunction

  function automatic result_t st_only(logic [2:0] st, bit nmd);
    result_t r;
    r = '0; r.status = st; r.no_more_data = nmd;
    return r;
  endfunction

  initial begin
    row_t rows [$];
    item_t it;
    int k, seq_len;
    for (int i = 0; i < NSRC; i++) begin
      drop_queue(i); src_started[i] = 0; src_ended[i] = 0;
    end
    fill_on = 0;
    lim_dur = RST_MAX_DURATION; lim_bytes = RST_MAX_BYTES;
    low_water = RST_LOW_WATER; src_cnt = RST_SOURCE_COUNT;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: reset values, errors, extremes, every op
    rows.insert(rows.size(), mk_row(mk(OP_TICK, 0, 0, 0), 1, st_only(ST_OK, 1)));
    rows.insert(rows.size(), mk_row(mk(OP_READ, 0, 0, 0), 1, st_only(ST_NOT_STARTED, 1)));
    rows.insert(rows.size(),
                mk_row(mk(OP_FILL, 1, T_MAX, SZ_MAX), 1, st_only(ST_NOT_STARTED, 1)));
    rows.insert(rows.size(),
                mk_row(mk(OP_NONE, 3, T_MAX, 21'h1FFFFF), 1, st_only(ST_OK, 1)));
    rows.insert(rows.size(), mk_row(mk(OP_START, 0, 0, 0), 1, st_only(ST_OK, 0)));
    rows.insert(rows.size(), mk_row(mk(OP_START, 0, 0, 0), 1, st_only(ST_OK, 0)));
    rows.insert(rows.size(), mk_row(mk(OP_READ, 0, 0, 0), 1, st_only(ST_EMPTY, 0)));
    rows.insert(rows.size(), mk_row(mk(OP_FILL, 0, T_MAX, SZ_MAX), 0, '0));
    rows.insert(rows.size(), mk_row(mk(OP_FILL, 0, 40'd0, 21'd0), 0, '0));
    rows.insert(rows.size(), mk_row(mk(OP_TICK, 0, 0, 0), 0, '0));
    rows.insert(rows.size(), mk_row(mk(OP_FILL, 0, 40'd7000000, 21'h1FFFFF), 0, '0));
    rows.insert(rows.size(), mk_row(mk(OP_TICK, 0, 0, 0), 0, '0));
    rows.insert(rows.size(), mk_row(mk(OP_READ, 0, 0, 0), 0, '0));
    rows.insert(rows.size(), mk_row(mk(OP_READ, 0, 0, 0), 0, '0));
    rows.insert(rows.size(), mk_row(mk(OP_END, 0, 0, 0), 0, '0));
    rows.insert(rows.size(), mk_row(mk(OP_TICK, 0, 0, 0), 0, '0));
    rows.insert(rows.size(), mk_row(mk(OP_READ, 0, 0, 0), 0, '0));
    rows.insert(rows.size(),
                mk_row(mk(OP_READ, 0, 0, 0), 1, st_only(ST_EMPTY_ENDED, 1)));
    rows.insert(rows.size(), mk_row(mk(OP_SEEK, 0, 0, 0), 1, st_only(ST_OK, 0)));
    rows.insert(rows.size(), mk_row(mk(OP_STOP, 0, 0, 0), 1, st_only(ST_OK, 1)));
    rows.insert(rows.size(), mk_row(mk(OP_SEEK, 2, 0, 0), 1, st_only(ST_NOT_STARTED, 1)));
    rows.insert(rows.size(), mk_row(mk(OP_STOP, 3, 0, 0), 1, st_only(ST_NOT_STARTED, 1)));
    foreach (rows[i]) issue(rows[i].it, rows[i].has_exp, rows[i].exp_r);

    // Fill one queue past full
    write_reg(REG_SOURCE_COUNT, 40'd4);
    issue(mk(OP_START, 1, 0, 0));
    for (int i = 0; i < DEPTH + 2; i++)
      issue(mk(OP_FILL, 1, 40'(i * 100000), SZ_MAX));
    issue(mk(OP_TICK, 0, 0, 0));
    issue(mk(OP_SEEK, 1, 0, 0));

    // Random phases across several register settings
    for (int ph = 0; ph < 8; ph++) begin
      quiet = (ph == 7);
      case (ph)
        0: begin
          write_reg(REG_MAX_DURATION, 40'd0); write_reg(REG_MAX_BYTES, 40'd0);
          write_reg(REG_LOW_WATER, 40'd0); write_reg(REG_SOURCE_COUNT, 40'd0);
        end
        1: begin
          write_reg(REG_MAX_DURATION, T_MAX); write_reg(REG_MAX_BYTES, 40'hFFFF_FFFF);
          write_reg(REG_LOW_WATER, T_MAX); write_reg(REG_SOURCE_COUNT, 40'd7);
        end
        default: begin
          write_reg(REG_MAX_DURATION, 40'($urandom_range(0, 3000)));
          write_reg(REG_MAX_BYTES, 40'($urandom_range(0, 4000000)));
          write_reg(REG_LOW_WATER, 40'($urandom_range(0, 2000)));
          write_reg(REG_SOURCE_COUNT, 40'($urandom_range(1, 5)));
        end
      endcase
      for (int n = 0; n < 24; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          // noise: any op, any fields
          it = mk(3'($urandom), 2'($urandom), {8'($urandom), 32'($urandom)},
                  21'($urandom_range(0, SZ_MAX)));
          issue(it);
        end else begin
          // well-formed: start, burst of fills with random times, a tick, maybe a read, end, seek or stop
          k = $urandom_range(0, 3);
          issue(mk(OP_START, 2'(k), 0, 0));
          seq_len = $urandom_range(1, 6);
          for (int j = 0; j < seq_len; j++) begin
            it = mk(OP_FILL, 2'(k), 40'($urandom_range(0, 4000)),
                    ($urandom_range(0, 9) == 0) ? SZ_MAX : 21'($urandom_range(0, 900000)));
            if ($urandom_range(0, 15) == 0) it.time_us = T_MAX;
            issue(it);
          end
          issue(mk(OP_TICK, 2'($urandom), 0, 0));
          if ($urandom_range(0, 1)) issue(mk(OP_READ, 2'(k), 0, 0));
          if ($urandom_range(0, 5) == 0) issue(mk(OP_END, 2'(k), 0, 0));
          if ($urandom_range(0, 7) == 0) issue(mk(OP_SEEK, 2'(k), 0, 0));
          if ($urandom_range(0, 9) == 0) issue(mk(OP_STOP, 2'(k), 0, 0));
          n = n + 1;
        end
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
